// File: hdl/ibanck_pkg.sv
package ibanck_pkg;

  // Stream framing and arithmetic constants
  localparam int unsigned HeadChars = 4;
  localparam int unsigned Modulus   = 97;
  localparam int unsigned LenSat    = 35;
  localparam int unsigned MinReset  = 15;
  localparam int unsigned MaxReset  = 34;
  localparam int unsigned ExpW      = $clog2(2 * HeadChars + 1);
  localparam int unsigned ProdW     = 14;
  localparam int unsigned RecipSh   = 20;
  localparam int unsigned Recip     = ((2 ** RecipSh) + Modulus - 1) / Modulus;

  // Character codes
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] CaseGap = 8'd32;
  localparam logic [7:0] LetterBase = 8'd10;

  // FIFO between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Configuration port
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;
  localparam logic        RegMin   = 1'b0;
  localparam logic        RegMax   = 1'b1;

  typedef enum logic [2:0] {
    CauseOk       = 3'd0,
    CauseLength   = 3'd1,
    CauseCountry  = 3'd2,
    CauseIllegal  = 3'd3,
    CauseChecksum = 3'd4
  } cause_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_t;

  typedef struct packed {
    logic       valid_res;
    cause_e     cause;
    logic [5:0] kept_length;
  } res_t;

  // Classified character as queued for the back end
  typedef struct packed {
    logic       kept;
    logic       legal;
    logic       letter;
    logic [5:0] value;
    logic       last;
  } cls_t;

  typedef struct packed {
    logic [5:0] min_length;
    logic [5:0] max_length;
  } cfg_t;

  typedef logic [6:0] mod_tab_t [Modulus];
  typedef logic [6:0] pow_tab_t [2 ** ExpW];

  function automatic mod_tab_t build_mul_tab(input int unsigned k);
    mod_tab_t t;
    for (int unsigned i = 0; i < Modulus; i++) begin
      t[i] = 7'((i * k) % Modulus);
    end
    return t;
  endfunction

  function automatic pow_tab_t build_pow_tab();
    pow_tab_t    t;
    int unsigned p;
    p = 1;
    for (int unsigned i = 0; i < 2 ** ExpW; i++) begin
      t[i] = 7'(p);
      p    = (p * 10) % Modulus;
    end
    return t;
  endfunction

  localparam mod_tab_t Mul10Tab  = build_mul_tab(10);
  localparam mod_tab_t Mul100Tab = build_mul_tab(100);
  localparam pow_tab_t Pow10Tab  = build_pow_tab();

  // Fold one character value into a remainder below the modulus
  function automatic logic [6:0] fold(input logic [6:0] rem, input logic [5:0] value,
                                      input logic letter);
    logic [6:0] t;
    logic [7:0] s;
    t = letter ? Mul100Tab[rem] : Mul10Tab[rem];
    s = {1'b0, t} + {2'b00, value};
    if (s >= 8'(Modulus)) begin
      s = s - 8'(Modulus);
    end
    return s[6:0];
  endfunction

endpackage

// File: hdl/ibanck_regs.sv
module ibanck_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ibanck_pkg::PaddrW-1:0] paddr,
  input  logic [ibanck_pkg::PdataW-1:0] pwdata,
  output logic [ibanck_pkg::PdataW-1:0] prdata,
  output logic                          pready,
  output ibanck_pkg::cfg_t              cfg_o
);

  logic [5:0] min_q, min_d;
  logic [5:0] max_q, max_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Decode register writes
  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (wr_en) begin
      case (paddr[2])
        ibanck_pkg::RegMin: min_d = pwdata[5:0];
        ibanck_pkg::RegMax: max_d = pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= 6'(ibanck_pkg::MinReset);
      max_q <= 6'(ibanck_pkg::MaxReset);
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  // Return the addressed register
  always_comb begin
    case (paddr[2])
      ibanck_pkg::RegMin: prdata = {{(ibanck_pkg::PdataW - 6){1'b0}}, min_q};
      ibanck_pkg::RegMax: prdata = {{(ibanck_pkg::PdataW - 6){1'b0}}, max_q};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o.min_length = min_q;
  assign cfg_o.max_length = max_q;

endmodule

// File: hdl/ibanck_front.sv
module ibanck_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ibanck_pkg::in_t   in_data_i,
  output logic              push_o,
  output ibanck_pkg::cls_t  push_data_o,
  input  logic              full_i
);

  logic [7:0] c;
  logic [7:0] up;
  logic       drop;
  logic       digit;
  logic       letter;

  assign c = in_data_i.char_code;

  // Classify the raw byte
  always_comb begin
    drop   = (c == ibanck_pkg::ChSpace) || (c == ibanck_pkg::ChDash) ||
             (c == ibanck_pkg::ChSlash) ||
             ((c >= ibanck_pkg::ChTab) && (c <= ibanck_pkg::ChCr));
    up     = ((c >= ibanck_pkg::ChLowA) && (c <= ibanck_pkg::ChLowZ)) ?
             (c - ibanck_pkg::CaseGap) : c;
    digit  = (up >= ibanck_pkg::ChZero) && (up <= ibanck_pkg::ChNine);
    letter = (up >= ibanck_pkg::ChUpA) && (up <= ibanck_pkg::ChUpZ);

    push_data_o.kept   = !drop;
    push_data_o.legal  = digit || letter;
    push_data_o.letter = letter;
    push_data_o.last   = in_data_i.last;
    if (digit) begin
      push_data_o.value = 6'(up - ibanck_pkg::ChZero);
    end else if (letter) begin
      push_data_o.value = 6'(up - ibanck_pkg::ChUpA + ibanck_pkg::LetterBase);
    end else begin
      push_data_o.value = '0;
    end
  end

  // Queue kept characters and every end of string; drop the rest here
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i && (!drop || in_data_i.last);

endmodule

// File: hdl/ibanck_fifo.sv
module ibanck_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ibanck_pkg::cls_t  push_data_i,
  output logic              full_o,
  output logic              pop_valid_o,
  input  logic              pop_i,
  output ibanck_pkg::cls_t  pop_data_o
);

  ibanck_pkg::cls_t                    mem_q [ibanck_pkg::FifoDepth];
  logic [ibanck_pkg::FifoPtrW-1:0]     wr_q, wr_d;
  logic [ibanck_pkg::FifoPtrW-1:0]     rd_q, rd_d;
  logic [ibanck_pkg::FifoCntW-1:0]     cnt_q, cnt_d;
  logic                                do_pop;

  assign full_o      = (cnt_q == ibanck_pkg::FifoCntW'(ibanck_pkg::FifoDepth));
  assign pop_valid_o = (cnt_q != '0);
  assign do_pop      = pop_i && pop_valid_o;
  assign pop_data_o  = mem_q[rd_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold queued entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: hdl/ibanck_back.sv
module ibanck_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ibanck_pkg::cfg_t  cfg_i,
  input  logic              pop_valid_i,
  input  ibanck_pkg::cls_t  pop_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ibanck_pkg::res_t  out_data_o
);

  typedef struct packed {
    logic [6:0]                   rem;
    logic [6:0]                   hacc;
    logic [ibanck_pkg::ExpW-1:0]  shift;
    logic [5:0]                   cnt;
    logic                         illegal;
    logic                         country;
  } snap_t;

  typedef struct packed {
    logic [ibanck_pkg::ProdW-1:0] x;
    logic [5:0]                   cnt;
    logic                         illegal;
    logic                         country;
  } prod_t;

  // Per-string running state
  logic [5:0]                  cnt_q, cnt_d;
  logic [6:0]                  rem_q, rem_d;
  logic [6:0]                  hacc_q, hacc_d;
  logic [ibanck_pkg::ExpW-1:0] shift_q, shift_d;
  logic                        ill_q, ill_d;
  logic                        ctry_q, ctry_d;

  logic                        snap_valid_q, prod_valid_q, out_valid_q;
  snap_t                       snap_q, snap_d;
  prod_t                       prod_q, prod_d;
  ibanck_pkg::res_t            out_q, out_d;

  logic                        out_free, prod_adv, prod_free, snap_adv, snap_free;
  logic                        take_last;

  logic [2*ibanck_pkg::ProdW-1:0] recip_prod;
  logic [6:0]                     quo;
  logic [ibanck_pkg::ProdW-1:0]   rmd;
  logic [6:0]                     rem_fin;
  logic                           len_bad;

  // Pipeline flow control
  assign out_free  = !out_valid_q || out_ready_i;
  assign prod_adv  = prod_valid_q && out_free;
  assign prod_free = !prod_valid_q || prod_adv;
  assign snap_adv  = snap_valid_q && prod_free;
  assign snap_free = !snap_valid_q || snap_adv;
  assign pop_o     = pop_valid_i && (!pop_data_i.last || snap_free);
  assign take_last = pop_o && pop_data_i.last;

  // Update the running state with one character
  always_comb begin
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    hacc_d  = hacc_q;
    shift_d = shift_q;
    ill_d   = ill_q;
    ctry_d  = ctry_q;
    if (pop_o && pop_data_i.kept) begin
      if (!pop_data_i.legal) begin
        ill_d = 1'b1;
      end
      if ((cnt_q < 6'd2) && !pop_data_i.letter) begin
        ctry_d = 1'b1;
      end
      if (cnt_q < 6'(ibanck_pkg::HeadChars)) begin
        hacc_d  = ibanck_pkg::fold(hacc_q, pop_data_i.value, pop_data_i.letter);
        shift_d = shift_q + (pop_data_i.letter ? ibanck_pkg::ExpW'(2) : ibanck_pkg::ExpW'(1));
      end else if (pop_data_i.legal) begin
        rem_d = ibanck_pkg::fold(rem_q, pop_data_i.value, pop_data_i.letter);
      end
      if (cnt_q < 6'(ibanck_pkg::LenSat)) begin
        cnt_d = cnt_q + 6'd1;
      end
    end

    snap_d.rem     = rem_d;
    snap_d.hacc    = hacc_d;
    snap_d.shift   = shift_d;
    snap_d.cnt     = cnt_d;
    snap_d.illegal = ill_d;
    snap_d.country = ctry_d;

    // Clear for the next string
    if (take_last) begin
      cnt_d   = '0;
      rem_d   = '0;
      hacc_d  = '0;
      shift_d = '0;
      ill_d   = 1'b0;
      ctry_d  = 1'b0;
    end
  end

  // Shift the body remainder past the head and add the head's share
  always_comb begin
    prod_d.x       = ibanck_pkg::ProdW'(snap_q.rem * ibanck_pkg::Pow10Tab[snap_q.shift]) +
                     ibanck_pkg::ProdW'(snap_q.hacc);
    prod_d.cnt     = snap_q.cnt;
    prod_d.illegal = snap_q.illegal;
    prod_d.country = snap_q.country;
  end

  // Reduce modulo 97 by reciprocal and give the verdict
  always_comb begin
    recip_prod = (2*ibanck_pkg::ProdW)'(prod_q.x) * (2*ibanck_pkg::ProdW)'(ibanck_pkg::Recip);
    quo        = recip_prod[ibanck_pkg::RecipSh +: 7];
    rmd        = prod_q.x - ibanck_pkg::ProdW'(quo) * ibanck_pkg::ProdW'(ibanck_pkg::Modulus);
    rem_fin    = rmd[6:0];
    len_bad    = (prod_q.cnt < cfg_i.min_length) || (prod_q.cnt > cfg_i.max_length);

    if (len_bad) begin
      out_d.cause = ibanck_pkg::CauseLength;
    end else if (prod_q.country || (prod_q.cnt < 6'd2)) begin
      out_d.cause = ibanck_pkg::CauseCountry;
    end else if (prod_q.illegal) begin
      out_d.cause = ibanck_pkg::CauseIllegal;
    end else if (rem_fin != 7'd1) begin
      out_d.cause = ibanck_pkg::CauseChecksum;
    end else begin
      out_d.cause = ibanck_pkg::CauseOk;
    end
    out_d.valid_res   = (out_d.cause == ibanck_pkg::CauseOk);
    out_d.kept_length = prod_q.cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      rem_q        <= '0;
      hacc_q       <= '0;
      shift_q      <= '0;
      ill_q        <= 1'b0;
      ctry_q       <= 1'b0;
      snap_valid_q <= 1'b0;
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      hacc_q  <= hacc_d;
      shift_q <= shift_d;
      ill_q   <= ill_d;
      ctry_q  <= ctry_d;
      if (snap_free) begin
        snap_valid_q <= take_last;
      end
      if (prod_free) begin
        prod_valid_q <= snap_valid_q;
      end
      if (out_free) begin
        out_valid_q <= prod_valid_q;
      end
    end
  end

  // Advance payload stages
  always_ff @(posedge clk_i) begin
    if (take_last) begin
      snap_q <= snap_d;
    end
    if (snap_adv) begin
      prod_q <= prod_d;
    end
    if (prod_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/iban_checksum_validator.sv
// Streaming account-number (IBAN) mod-97 checker.
// Input channel: one raw byte per transaction (char_code, last) on valid/ready.
// Spaces, whitespace controls, '-' and '/' are dropped; letters are uppercased.
// Output channel: one verdict per string (valid_res, cause, kept_length),
// produced for the transaction that carries last.
// Throughput: one byte per cycle while the queue has room, set by the per-byte
// remainder step, which is a table lookup and one compare-subtract.
// Path: the last byte passes through the four-entry queue, the snapshot stage
// and the multiply stage, and the verdict is registered in the output register.
// Stall: while the receiver holds off, the verdict waits in the output
// register; bytes are still taken until the queue fills, then ready drops.
// Reset clears the queue, the pipeline and the per-string state, and sets
// min_length to 15 and max_length to 34. Registers sit on the APB port at
// byte addresses 0 (min_length) and 4 (max_length); write them only when idle.
module iban_checksum_validator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ibanck_pkg::in_t               in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ibanck_pkg::res_t              out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ibanck_pkg::PaddrW-1:0] paddr,
  input  logic [ibanck_pkg::PdataW-1:0] pwdata,
  output logic [ibanck_pkg::PdataW-1:0] prdata,
  output logic                          pready
);

  ibanck_pkg::cfg_t cfg;
  ibanck_pkg::cls_t push_data;
  ibanck_pkg::cls_t pop_data;
  logic             push;
  logic             full;
  logic             pop_valid;
  logic             pop;

  ibanck_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ibanck_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  ibanck_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_data)
  );

  ibanck_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sim/iban_checksum_validator_tb.sv
`timescale 1ns / 100ps

module iban_checksum_validator_tb;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 10;
  localparam int PhaseBytes   = 190;
  localparam int NumPhases    = 10;
  localparam int NoWrite      = -1;

  typedef enum int {RxFree, RxCoin, RxPeriodic, RxSparse} rx_mode_e;
  typedef enum int {MutNone, MutChecksum, MutCountry, MutIllegal} mut_e;

  typedef struct {
    int               cfg_min;
    logic [7:0]       code;
    logic             last;
    bit               has_verdict;
    ibanck_pkg::res_t verdict;
  } stim_row_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  ibanck_pkg::in_t               in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  ibanck_pkg::res_t              out_data_o;
  logic                          psel        = 1'b0;
  logic                          penable     = 1'b0;
  logic                          pwrite      = 1'b0;
  logic [ibanck_pkg::PaddrW-1:0] paddr       = '0;
  logic [ibanck_pkg::PdataW-1:0] pwdata      = '0;
  logic [ibanck_pkg::PdataW-1:0] prdata;
  logic                          pready;

  // Predictor state and its copy of the registers
  logic [5:0] cfg_min = 6'(ibanck_pkg::MinReset);
  logic [5:0] cfg_max = 6'(ibanck_pkg::MaxReset);
  logic [5:0] head_vals [ibanck_pkg::HeadChars];
  logic [5:0] kept_cnt    = '0;
  logic [6:0] run_rem     = '0;
  bit         illegal_hit = 1'b0;
  bit         country_err = 1'b0;

  ibanck_pkg::res_t pending_verdicts [$];
  logic [7:0]       text_q [$];
  int               mismatch_count = 0;
  int               cycle_count    = 0;
  int               tx_burst_left  = 0;
  rx_mode_e         rx_mode        = RxFree;
  int               rx_left        = 0;
  int               rx_tick        = 0;

  // Directed stimulus: single bytes after reset, a valid Norwegian number, then each cause
  stim_row_t directed_tab [28] = '{
    '{NoWrite, ibanck_pkg::ChSpace, 1'b1, 1'b1, '{1'b0, ibanck_pkg::CauseLength, 6'd0}},
    '{NoWrite, 8'hFF,   1'b1, 1'b1, '{1'b0, ibanck_pkg::CauseLength, 6'd1}},
    '{NoWrite, 8'h00,   1'b1, 1'b1, '{1'b0, ibanck_pkg::CauseLength, 6'd1}},
    '{NoWrite, "n",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, "o",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, "9",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, "3",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, ibanck_pkg::ChTab, 1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, "8",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, "6",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, "0",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, "1",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, ibanck_pkg::ChSlash, 1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, "1",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, "1",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, "1",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, "7",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, ibanck_pkg::ChDash, 1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, "9",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, "4",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, "7",     1'b1, 1'b1, '{1'b1, ibanck_pkg::CauseOk, 6'd15}},
    '{1,       "1",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, ibanck_pkg::ChCr, 1'b1, 1'b1, '{1'b0, ibanck_pkg::CauseCountry, 6'd1}},
    '{NoWrite, "A",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, "B",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, 8'h80,   1'b1, 1'b1, '{1'b0, ibanck_pkg::CauseIllegal, 6'd3}},
    '{NoWrite, "a",     1'b0, 1'b0, '{1'b0, ibanck_pkg::CauseOk, 6'd0}},
    '{NoWrite, "Z",     1'b1, 1'b1, '{1'b0, ibanck_pkg::CauseChecksum, 6'd2}}
  };

  // Register settings per random phase; a negative entry takes a random bound
  int phase_min [NumPhases] = '{15, 1, 34, 1, 20, 0, 63, 8, -1, -1};
  int phase_max [NumPhases] = '{34, 34, 34, 1, 10, 63, 0, 24, -1, -1};

  iban_checksum_validator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // One mod-97 step: a letter shifts by two decimal places, a digit by one
  function automatic logic [6:0] mod97_fold(input logic [6:0] rem, input logic [5:0] v);
    int acc;
    acc = (v > 6'd9) ? int'(rem) * 100 + int'(v) : int'(rem) * 10 + int'(v);
    return 7'(acc % ibanck_pkg::Modulus);
  endfunction

  // Advance the predictor by one byte; return 1 when the byte closes a string
  function automatic bit verdict_for_byte(input ibanck_pkg::in_t b,
                                          output ibanck_pkg::res_t r);
    logic [7:0]         c;
    logic [5:0]         v;
    logic [6:0]         rem;
    bit                 legal;
    bit                 letter;
    int                 held;
    ibanck_pkg::cause_e cause;
    c = b.char_code;
    r = '0;
    if (!(c == ibanck_pkg::ChSpace ||
          (c >= ibanck_pkg::ChTab && c <= ibanck_pkg::ChCr) ||
          c == ibanck_pkg::ChDash || c == ibanck_pkg::ChSlash)) begin
      if (c >= ibanck_pkg::ChLowA && c <= ibanck_pkg::ChLowZ) begin
        c = c - ibanck_pkg::CaseGap;
      end
      legal  = 1'b1;
      letter = 1'b0;
      v      = '0;
      if (c >= ibanck_pkg::ChZero && c <= ibanck_pkg::ChNine) begin
        v = 6'(c - ibanck_pkg::ChZero);
      end else if (c >= ibanck_pkg::ChUpA && c <= ibanck_pkg::ChUpZ) begin
        v      = 6'(c - ibanck_pkg::ChUpA + ibanck_pkg::LetterBase);
        letter = 1'b1;
      end else begin
        legal = 1'b0;
      end
      if (!legal) illegal_hit = 1'b1;
      if (kept_cnt < 2 && !letter) country_err = 1'b1;
      if (kept_cnt < ibanck_pkg::HeadChars) begin
        head_vals[kept_cnt[$clog2(ibanck_pkg::HeadChars)-1:0]] = v;
      end else if (legal) begin
        run_rem = mod97_fold(run_rem, v);
      end
      if (kept_cnt < ibanck_pkg::LenSat) kept_cnt = kept_cnt + 6'd1;
    end
    if (!b.last) return 1'b0;

    // Fold in the held head after the rest of the string
    rem  = run_rem;
    held = (kept_cnt < ibanck_pkg::HeadChars) ? int'(kept_cnt) : ibanck_pkg::HeadChars;
    for (int i = 0; i < held; i++) begin
      rem = mod97_fold(rem, head_vals[i]);
    end
    if (kept_cnt < cfg_min || kept_cnt > cfg_max) begin
      cause = ibanck_pkg::CauseLength;
    end else if (country_err || kept_cnt < 2) begin
      cause = ibanck_pkg::CauseCountry;
    end else if (illegal_hit) begin
      cause = ibanck_pkg::CauseIllegal;
    end else if (rem != 7'd1) begin
      cause = ibanck_pkg::CauseChecksum;
    end else begin
      cause = ibanck_pkg::CauseOk;
    end
    r.valid_res   = (cause == ibanck_pkg::CauseOk);
    r.cause       = cause;
    r.kept_length = kept_cnt;

    kept_cnt    = '0;
    run_rem     = '0;
    illegal_hit = 1'b0;
    country_err = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] value_char(input logic [5:0] v);
    return (v < 6'd10) ? ibanck_pkg::ChZero + 8'(v) :
                         ibanck_pkg::ChUpA + 8'(v) - ibanck_pkg::LetterBase;
  endfunction

  function automatic logic [7:0] sep_byte();
    case ($urandom_range(0, 3))
      0:       return ibanck_pkg::ChSpace;
      1:       return 8'($urandom_range(ibanck_pkg::ChTab, ibanck_pkg::ChCr));
      2:       return ibanck_pkg::ChDash;
      default: return ibanck_pkg::ChSlash;
    endcase
  endfunction

  // A random kept byte that is neither digit nor letter, including the high half
  function automatic logic [7:0] illegal_byte();
    case ($urandom_range(0, 6))
      0:       return 8'($urandom_range(0, 8));
      1:       return 8'($urandom_range(14, 31));
      2:       return 8'($urandom_range(33, 44));
      3:       return 8'($urandom_range(58, 64));
      4:       return 8'($urandom_range(91, 96));
      5:       return 8'($urandom_range(123, 127));
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  // Fill text_q with one string: mostly well-formed numbers, some noise and short ones
  task automatic compose_string();
    int         kind;
    int         len;
    int         lo;
    int         hi;
    int         chk;
    int         sep_pct;
    int         ill_pos;
    bit         lower;
    mut_e       mut;
    logic [5:0] vals [$];
    logic [6:0] r;
    logic [7:0] c;
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      lo = (cfg_min < 5) ? 5 : int'(cfg_min);
      hi = (cfg_max > 34) ? 34 : int'(cfg_max);
      if (lo > hi) begin
        lo = 5;
        hi = 34;
      end
      len = $urandom_range(hi, lo);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(35, 40);
      vals = {vals, 6'($urandom_range(10, 35))};
      vals = {vals, 6'($urandom_range(10, 35))};
      vals = {vals, 6'd0};
      vals = {vals, 6'd0};
      for (int i = 4; i < len; i++) begin
        if ($urandom_range(0, 3) == 0) vals = {vals, 6'($urandom_range(10, 35))};
        else vals = {vals, 6'($urandom_range(0, 9))};
      end
      // Check digits: remainder with 00 in place, then 98 minus it
      r = '0;
      for (int i = 4; i < len; i++) r = mod97_fold(r, vals[i]);
      for (int i = 0; i < 4; i++) r = mod97_fold(r, vals[i]);
      chk     = 98 - int'(r);
      vals[2] = 6'(chk / 10);
      vals[3] = 6'(chk % 10);

      mut     = ($urandom_range(0, 9) < 7) ? MutNone : mut_e'($urandom_range(1, 3));
      ill_pos = -1;
      case (mut)
        MutChecksum: begin
          lo       = $urandom_range(2, len - 1);
          vals[lo] = vals[lo] ^ 6'd1;
        end
        MutCountry: vals[$urandom_range(0, 1)] = 6'($urandom_range(0, 9));
        MutIllegal: ill_pos = $urandom_range(0, len - 1);
        default: ;
      endcase

      // Render with optional lowercase and separators
      lower = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 2))
        0:       sep_pct = 0;
        1:       sep_pct = 10;
        default: sep_pct = 30;
      endcase
      for (int i = 0; i < len; i++) begin
        c = value_char(vals[i]);
        if (lower && vals[i] > 6'd9 && $urandom_range(0, 1) == 1) c = c + ibanck_pkg::CaseGap;
        if (i == ill_pos) c = illegal_byte();
        text_q = {text_q, c};
        if (i < len - 1 && $urandom_range(0, 99) < sep_pct) text_q = {text_q, sep_byte()};
      end
      if ($urandom_range(0, 7) == 0) text_q = {text_q, sep_byte()};
    end else if (kind < 85) begin
      len = $urandom_range(1, 14);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 4))
          0, 1:    c = 8'($urandom_range(0, 255));
          2:       c = value_char(6'($urandom_range(0, 35)));
          3:       c = ibanck_pkg::ChLowA + 8'($urandom_range(0, 25));
          default: c = sep_byte();
        endcase
        text_q = {text_q, c};
      end
    end else begin
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 3) == 0) text_q = {text_q, sep_byte()};
        else text_q = {text_q, value_char(6'($urandom_range(0, 35)))};
      end
    end
  endtask

  // Offer one byte, hold it until taken, then maybe idle between bursts
  task automatic send_byte(input ibanck_pkg::in_t b, input bit has_v,
                           input ibanck_pkg::res_t fixed_v);
    ibanck_pkg::res_t pred;
    int               gap;
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (verdict_for_byte(b, pred)) begin
      pending_verdicts = {pending_verdicts, (has_v ? fixed_v : pred)};
    end
    if (tx_burst_left > 0) begin
      tx_burst_left--;
    end else begin
      tx_burst_left = $urandom_range(0, 40);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(4, 20);
        default: gap = $urandom_range(1, 3);
      endcase
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_string();
    ibanck_pkg::in_t b;
    for (int i = 0; i < text_q.size(); i++) begin
      b.char_code = text_q[i];
      b.last      = (i == text_q.size() - 1);
      send_byte(b, 1'b0, '0);
    end
  endtask

  // Drop valid, wait for every verdict, then let the pipeline empty
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write one register over APB, then read it back
  task automatic program_reg(input logic reg_sel, input logic [5:0] val);
    logic [ibanck_pkg::PdataW-1:0] word;
    word    = ($urandom() & ~ibanck_pkg::PdataW'(6'h3F)) | ibanck_pkg::PdataW'(val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_sel == ibanck_pkg::RegMin) cfg_min = val;
    else cfg_max = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    if (prdata !== ibanck_pkg::PdataW'(val)) begin
      $error("register readback mismatch: expected %0d, actual %0d", val, prdata);
      mismatch_count++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: switch between free flow, coin-toss, periodic and sparse stalls
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(30, 300);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      RxFree:     out_ready_i <= 1'b1;
      RxCoin:     out_ready_i <= 1'($urandom_range(0, 1));
      RxPeriodic: out_ready_i <= ((rx_tick % 11) >= 6);
      default:    out_ready_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Compare each verdict transaction with the oldest pending one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected verdict: valid_res %0d cause %0d kept_length %0d",
               out_data_o.valid_res, out_data_o.cause, out_data_o.kept_length);
        mismatch_count++;
      end else begin
        if (out_data_o.valid_res !== pending_verdicts[0].valid_res) begin
          $error("valid_res mismatch: expected %0d, actual %0d",
                 pending_verdicts[0].valid_res, out_data_o.valid_res);
          mismatch_count++;
        end
        if (out_data_o.cause !== pending_verdicts[0].cause) begin
          $error("cause mismatch: expected %0d, actual %0d",
                 pending_verdicts[0].cause, out_data_o.cause);
          mismatch_count++;
        end
        if (out_data_o.kept_length !== pending_verdicts[0].kept_length) begin
          $error("kept_length mismatch: expected %0d, actual %0d",
                 pending_verdicts[0].kept_length, out_data_o.kept_length);
          mismatch_count++;
        end
        void'(pending_verdicts.pop_front());
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("iban_checksum_validator_tb failed");
      $finish;
    end
  end

  initial begin
    ibanck_pkg::in_t b;
    int              bytes_sent;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (directed_tab[i]) begin
      if (directed_tab[i].cfg_min != NoWrite) begin
        drain_and_settle();
        program_reg(ibanck_pkg::RegMin, 6'(directed_tab[i].cfg_min));
      end
      b.char_code = directed_tab[i].code;
      b.last      = directed_tab[i].last;
      send_byte(b, directed_tab[i].has_verdict, directed_tab[i].verdict);
    end

    // Random strings under each register setting
    for (int p = 0; p < NumPhases; p++) begin
      drain_and_settle();
      program_reg(ibanck_pkg::RegMin,
                  6'((phase_min[p] < 0) ? $urandom_range(1, 34) : phase_min[p]));
      program_reg(ibanck_pkg::RegMax,
                  6'((phase_max[p] < 0) ? $urandom_range(1, 34) : phase_max[p]));
      bytes_sent = 0;
      while (bytes_sent < PhaseBytes) begin
        compose_string();
        send_string();
        bytes_sent += text_q.size();
      end
    end

    drain_and_settle();
    if (mismatch_count == 0) begin
      $display("iban_checksum_validator_tb passed");
    end else begin
      $display("iban_checksum_validator_tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/ibanck_pkg.sv
hdl/ibanck_regs.sv
hdl/ibanck_front.sv
hdl/ibanck_fifo.sv
hdl/ibanck_back.sv
hdl/iban_checksum_validator.sv
sim/iban_checksum_validator_tb.sv
